[design/etst_pkg.sv]
package etst_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned LenW = 8;
  localparam int unsigned SizeW = 9;
  localparam logic [SizeW-1:0] SizeReset = 9'd128;

  localparam logic [CharW-1:0] ChNul = 8'h00;
  localparam logic [CharW-1:0] ChTilde = 8'h7E;
  localparam logic [CharW-1:0] ChQuote = 8'h22;
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChTab = 8'h09;

  localparam logic [CharW-1:0] ChLowR = 8'h72;
  localparam logic [CharW-1:0] ChLowN = 8'h6E;
  localparam logic [CharW-1:0] ChLowL = 8'h6C;
  localparam logic [CharW-1:0] ChLowT = 8'h74;
  localparam logic [CharW-1:0] ChLowB = 8'h62;
  localparam logic [CharW-1:0] ChLowF = 8'h66;
  localparam logic [CharW-1:0] ChLowE = 8'h65;

  localparam logic [CharW-1:0] CodeCr = 8'd13;
  localparam logic [CharW-1:0] CodeLf = 8'd10;
  localparam logic [CharW-1:0] CodeHt = 8'd9;
  localparam logic [CharW-1:0] CodeBs = 8'd8;
  localparam logic [CharW-1:0] CodeFf = 8'd12;
  localparam logic [CharW-1:0] CodeEsc = 8'd27;

  typedef struct packed {
    logic             is_end;
    logic [CharW-1:0] char_out;
    logic [LenW-1:0]  token_length;
    logic             truncated;
    logic             string_done;
  } result_t;

  typedef struct packed {
    logic             valid;
    logic [CharW-1:0] char_in;
  } item_t;

  function automatic logic [CharW-1:0] escape_map(input logic [CharW-1:0] c);
    logic [CharW-1:0] m;
    case (c)
      ChLowR: m = CodeCr;
      ChLowN: m = CodeCr;
      ChLowL: m = CodeLf;
      ChLowT: m = CodeHt;
      ChLowB: m = CodeBs;
      ChLowF: m = CodeFf;
      ChLowE: m = CodeEsc;
      default: m = c;
    endcase
    return m;
  endfunction

endpackage

[design/etst_in_if.sv]
interface etst_in_if;
  logic                          valid;
  logic                          ready;
  logic [etst_pkg::CharW-1:0]    char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

[design/etst_out_if.sv]
interface etst_out_if;
  logic                        valid;
  logic                        ready;
  logic                        is_end;
  logic [etst_pkg::CharW-1:0]  char_out;
  logic [etst_pkg::LenW-1:0]   token_length;
  logic                        truncated;
  logic                        string_done;

  modport source (output valid, output is_end, output char_out, output token_length,
                  output truncated, output string_done, input ready);
  modport sink (input valid, input is_end, input char_out, input token_length,
                input truncated, input string_done, output ready);
endinterface

[design/etst_cfg_if.sv]
interface etst_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [etst_pkg::SizeW-1:0]  token_size;

  modport source (output valid, output token_size, input ready);
  modport sink (input valid, input token_size, output ready);
endinterface

[design/etst_in_reg.sv]
module etst_in_reg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [etst_pkg::CharW-1:0] char_i,
  output logic                       ready_o,
  input  logic                       step_i,
  output etst_pkg::item_t            item_o
);

  logic                       valid_q, valid_d;
  logic [etst_pkg::CharW-1:0] char_q;
  logic                       load;

  assign ready_o = !valid_q || step_i;
  assign load = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (step_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= char_i;
    end
  end

  assign item_o.valid = valid_q;
  assign item_o.char_in = char_q;

endmodule

[design/etst_lexer.sv]
module etst_lexer #(
  parameter int unsigned MAX_SIZE = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [etst_pkg::CharW-1:0] char_i,
  input  logic [etst_pkg::SizeW-1:0] token_size_i,
  output logic                       has_result_o,
  output etst_pkg::result_t          result_o
);

  localparam int unsigned SizeTop = (MAX_SIZE < 511) ? MAX_SIZE : 511;
  localparam int unsigned CntW = $clog2(SizeTop);

  logic            in_token_q, in_token_d;
  logic            quoted_q, quoted_d;
  logic            esc_q, esc_d;
  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;

  logic [12:0]     size_ext;
  logic [CntW-1:0] limit;
  logic            is_ws;
  logic            do_keep;
  logic            do_end;
  logic            end_done;
  logic [etst_pkg::CharW-1:0] keep_char;

  assign size_ext = 13'(token_size_i);

  always_comb begin
    if (size_ext == 13'd0) begin
      limit = '0;
    end else if (size_ext > 13'(MAX_SIZE)) begin
      limit = CntW'(MAX_SIZE - 1);
    end else begin
      limit = CntW'(size_ext - 13'd1);
    end
  end

  assign is_ws = (char_i == etst_pkg::ChSpace) || (char_i == etst_pkg::ChTab);

  always_comb begin
    in_token_d = in_token_q;
    quoted_d = quoted_q;
    esc_d = esc_q;
    do_keep = 1'b0;
    do_end = 1'b0;
    end_done = 1'b0;
    keep_char = char_i;
    if (char_i == etst_pkg::ChNul) begin
      do_end = 1'b1;
      end_done = 1'b1;
    end else if (esc_q) begin
      esc_d = 1'b0;
      do_keep = 1'b1;
      keep_char = etst_pkg::escape_map(char_i);
    end else if (!in_token_q && is_ws) begin
      in_token_d = 1'b0;
    end else begin
      in_token_d = 1'b1;
      if (char_i == etst_pkg::ChTilde) begin
        esc_d = 1'b1;
      end else if (quoted_q && (char_i == etst_pkg::ChQuote)) begin
        do_end = 1'b1;
      end else if (!quoted_q && is_ws) begin
        do_end = 1'b1;
      end else begin
        if (char_i == etst_pkg::ChQuote) begin
          quoted_d = 1'b1;
        end
        do_keep = 1'b1;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    ovf_d = ovf_q;
    has_result_o = 1'b0;
    result_o = '0;
    if (do_end) begin
      has_result_o = 1'b1;
      result_o.is_end = 1'b1;
      result_o.token_length = etst_pkg::LenW'(count_q);
      result_o.truncated = ovf_q;
      result_o.string_done = end_done;
      count_d = '0;
      ovf_d = 1'b0;
    end else if (do_keep) begin
      if (count_q < limit) begin
        count_d = count_q + CntW'(1);
        has_result_o = 1'b1;
        result_o.char_out = keep_char;
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_token_q <= 1'b0;
      quoted_q <= 1'b0;
      esc_q <= 1'b0;
      count_q <= '0;
      ovf_q <= 1'b0;
    end else if (step_i) begin
      if (do_end) begin
        in_token_q <= 1'b0;
        quoted_q <= 1'b0;
        esc_q <= 1'b0;
      end else begin
        in_token_q <= in_token_d;
        quoted_q <= quoted_d;
        esc_q <= esc_d;
      end
      count_q <= count_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

[design/etst_out_reg.sv]
module etst_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  etst_pkg::result_t result_i,
  input  logic              ready_i,
  output logic              free_o,
  output logic              valid_o,
  output etst_pkg::result_t result_o
);

  logic              valid_q, valid_d;
  etst_pkg::result_t result_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o = valid_q;
  assign result_o = result_q;

endmodule

[design/escaped_token_splitter.sv]
// Channel  | Role   | Payload
// in_ch    | sink   | char_in (8 bits, 0 ends the string)
// out_ch   | source | is_end, char_out, token_length, truncated, string_done
// cfg_ch   | sink   | token_size (9 bits, reset value 128)
//
// One item is taken per cycle while the input register is empty or drains;
// a token byte or end marker is offered on out_ch after its item passes the
// input register, the scanner logic and the result register, in that order;
// a stalled output holds the item back in the input register.
// Reset clears the scanner state and both stage valid bits.
// A stalled output holds its item; input is still taken while the input
// register can drain into the result register.
module escaped_token_splitter #(
  parameter int unsigned MAX_SIZE = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  etst_in_if.sink         in_ch,
  etst_out_if.source      out_ch,
  etst_cfg_if.sink        cfg_ch
);

  logic [etst_pkg::SizeW-1:0] token_size_q;
  etst_pkg::item_t            item;
  etst_pkg::result_t          lex_res;
  etst_pkg::result_t          out_res;
  logic                       has_result;
  logic                       out_free;
  logic                       step;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_size_q <= etst_pkg::SizeReset;
    end else if (cfg_ch.valid) begin
      token_size_q <= cfg_ch.token_size;
    end
  end

  assign step = item.valid && out_free;

  etst_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_ch.valid),
    .char_i  (in_ch.char_in),
    .ready_o (in_ch.ready),
    .step_i  (step),
    .item_o  (item)
  );

  etst_lexer #(
    .MAX_SIZE (MAX_SIZE)
  ) u_lexer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .char_i       (item.char_in),
    .token_size_i (token_size_q),
    .has_result_o (has_result),
    .result_o     (lex_res)
  );

  etst_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (step && has_result),
    .result_i (lex_res),
    .ready_i  (out_ch.ready),
    .free_o   (out_free),
    .valid_o  (out_ch.valid),
    .result_o (out_res)
  );

  assign out_ch.is_end = out_res.is_end;
  assign out_ch.char_out = out_res.char_out;
  assign out_ch.token_length = out_res.token_length;
  assign out_ch.truncated = out_res.truncated;
  assign out_ch.string_done = out_res.string_done;

endmodule

[design/etst_checker.sv]
module etst_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic                       is_end_i,
  input logic [etst_pkg::CharW-1:0] char_out_i,
  input logic [etst_pkg::LenW-1:0]  token_length_i,
  input logic                       truncated_i,
  input logic                       string_done_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(char_out_i)
      && $stable(is_end_i) && $stable(token_length_i))
    else $error("Stalled output item changed.");

  a_end_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_end_i |-> char_out_i == '0)
    else $error("End marker carries a byte.");

  a_byte_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !is_end_i |-> token_length_i == '0 && !truncated_i && !string_done_i)
    else $error("Token byte carries end marker fields.");

  a_byte_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !is_end_i |-> char_out_i != '0)
    else $error("Token byte is zero.");

endmodule

bind escaped_token_splitter etst_checker u_etst_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_ch.valid),
  .out_ready_i    (out_ch.ready),
  .is_end_i       (out_ch.is_end),
  .char_out_i     (out_ch.char_out),
  .token_length_i (out_ch.token_length),
  .truncated_i    (out_ch.truncated),
  .string_done_i  (out_ch.string_done)
);
